// ----- hdl/irt_pkg.sv -----
// Shared types, constants and helpers for the integer-to-radix-text core.
package irt_pkg;

    localparam int VALUE_BITS = 31;
    localparam int CELLS      = VALUE_BITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int DIGIT_W    = 4;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A_OFS = 7'h57;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [1:0]            radix;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       conv;
        logic       emit;
        logic [1:0] radix;
    } t_cell_ctl;

    function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        if (d <= DIGIT_W'(9)) begin
            return CHAR_ZERO + {3'b000, d};
        end
        return CHAR_A_OFS + {3'b000, d};
    endfunction

endpackage

// ----- hdl/irt_cell.sv -----
// One digit cell: shift-and-adjust during conversion, shift toward the top on emit.
module irt_cell (
    input  logic                          i_clk,
    input  irt_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_carry,
    input  logic [irt_pkg::DIGIT_W-1:0]   i_digit_lo,
    output logic                          o_carry,
    output logic [irt_pkg::DIGIT_W-1:0]   o_digit
);
    import irt_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;
    logic               w_bin;
    logic               w_dec;

    assign w_bin = (i_ctl.radix == RADIX_BIN);
    assign w_dec = (i_ctl.radix == RADIX_DEC);
    assign w_adj = (w_dec && r_digit >= DIGIT_W'(5)) ? r_digit + DIGIT_W'(3) : r_digit;

    assign o_carry = w_bin ? r_digit[0] : w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        priority if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = w_bin ? {{(DIGIT_W-1){1'b0}}, i_carry} : {w_adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctl.emit) begin
            n_digit = i_digit_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ----- hdl/integer_to_radix_text_core.sv -----
// Top level: converts an unsigned integer to ASCII digits in base 2, 10 or 16.
//
//  channel | direction | handshake            | beat
//  in      | input     | i_in_valid/o_in_stall | t_in_beat  {value, radix}
//  out     | output    | o_out_valid/i_out_stall | t_out_beat {digit_char, last}
//
//  One item at a time. Accept cycle clears the cells, then the value is shifted
//  bit by bit through the digit chain (double dabble in decimal).
//  Emission then walks CELLS positions out of the top cell, skipping leading
//  zeros and delivering each digit in turn.
//  A stalled out beat holds the chain still. Reset returns to idle.
module integer_to_radix_text_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  irt_pkg::t_in_beat    i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output irt_pkg::t_out_beat   o_out_data,
    input  logic                 i_out_stall
);
    import irt_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  r_seen;
    logic                  n_seen;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] n_val;
    logic [1:0]            r_radix;
    logic [1:0]            n_radix;

    t_cell_ctl             w_ctl;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_skip;
    logic                  w_last;
    logic [DIGIT_W-1:0]    w_top;
    logic [CELLS-1:0]      w_carry;
    logic [DIGIT_W-1:0]    w_digit [CELLS];

    // digit chain, cell 0 least significant
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            irt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_carry    (r_val[VALUE_BITS-1]),
                .i_digit_lo ({DIGIT_W{1'b0}}),
                .o_carry    (w_carry[g]),
                .o_digit    (w_digit[g])
            );
        end else begin : g_rest
            irt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_carry    (w_carry[g-1]),
                .i_digit_lo (w_digit[g-1]),
                .o_carry    (w_carry[g]),
                .o_digit    (w_digit[g])
            );
        end
    end

    assign w_top     = w_digit[CELLS-1];
    assign w_last    = (r_cnt == CNT_W'(1));
    assign w_skip    = !r_seen && (w_top == '0) && !w_last;
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    assign o_out_data.digit_char = digit_to_ascii(w_top);
    assign o_out_data.last       = w_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                n_state = ST_CONV;
            end
            ST_CONV: if (w_last) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (w_out_acc && w_last) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        w_ctl.clear = 1'b0;
        w_ctl.conv  = 1'b0;
        w_ctl.emit  = 1'b0;
        w_ctl.radix = r_radix;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_ctl.clear = 1'b1;
            end
            ST_CONV: begin
                w_ctl.conv = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = !w_skip;
                w_ctl.emit  = w_skip || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        n_val   = r_val;
        n_radix = r_radix;
        priority if (w_in_acc) begin
            n_cnt   = CNT_W'(VALUE_BITS);
            n_seen  = 1'b0;
            n_val   = i_in_data.value;
            n_radix = i_in_data.radix;
        end else if (w_ctl.conv) begin
            n_val = {r_val[VALUE_BITS-2:0], 1'b0};
            n_cnt = w_last ? CNT_W'(CELLS) : r_cnt - CNT_W'(1);
        end else if (w_ctl.emit) begin
            n_cnt  = r_cnt - CNT_W'(1);
            n_seen = r_seen || w_out_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
        end
        r_val   <= n_val;
        r_radix <= n_radix;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.conv |-> !w_carry[CELLS-1])
        else $error("digit chain overflow");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input taken while digits pending");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_out_data.last) |=> o_out_valid)
        else $error("gap after a started number");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.digit_char >= 7'h30 && o_out_data.digit_char <= 7'h39)
                      || (o_out_data.digit_char >= 7'h61 && o_out_data.digit_char <= 7'h66)))
        else $error("digit character out of range");

    a_bin_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_radix == RADIX_BIN) |-> (w_top <= DIGIT_W'(1)))
        else $error("binary digit above one");
`endif

endmodule
